>>> rtl/core/critical_path_earliest_dates_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the earliest-date block
// Concurrent property shorthands used by the checker file cpe_checker.
// ----------------------------------------------------------------------------
`ifndef CRITICAL_PATH_EARLIEST_DATES_ASSERT_SVH
`define CRITICAL_PATH_EARLIEST_DATES_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CPE_ASSERT_IMP(lbl, clk_s, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define CPE_ASSERT_NXT(lbl, clk_s, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cpe_pkg.sv
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared widths, constants and the queue entry type of the earliest-date block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpe_pkg;

  localparam int CPE_MAX_VERTICES = 1024;
  localparam int CPE_MAX_PREDS    = 16;

  localparam int IDX_W  = 10;
  localparam int DUR_W  = 16;
  localparam int DATE_W = 32;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  // Queue between front and back end
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QLW    = $clog2(QDEPTH + 1);

  // Shift of the reciprocal used for index reduction
  localparam int RECIP_SH = 20;

  typedef struct packed {
    logic [IDX_W-1:0] vertex;
    logic [DUR_W-1:0] dur;
    logic [IDX_W-1:0] pred;
    logic [IDX_W-1:0] vrem;   // vertex reduced to a store slot
    logic [IDX_W-1:0] prem;   // predecessor reduced to a store slot
    logic             last;
  } cpe_qent_t;

endpackage

`default_nettype wire

>>> rtl/core/cpe_ram.sv
// ----------------------------------------------------------------------------
// cpe_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cpe_fifo.sv
// ----------------------------------------------------------------------------
// cpe_fifo
// Short request queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpe_fifo
  import cpe_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire cpe_qent_t      push_data,
  input  wire logic           pop,
  output cpe_qent_t           head,
  output logic [QLW-1:0]      level
);

  cpe_qent_t       mem_r [QDEPTH];
  logic [QPW-1:0]  wp_r;
  logic [QPW-1:0]  rp_r;
  logic [QLW-1:0]  lvl_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        lvl_r <= lvl_r + 1'b1;
      end else if (pop && !push) begin
        lvl_r <= lvl_r - 1'b1;
      end
    end
  end

  assign head  = mem_r[rp_r];
  assign level = lvl_r;

endmodule

`default_nettype wire

>>> rtl/core/cpe_front.sv
// ----------------------------------------------------------------------------
// cpe_front
// Accept requests, reduce vertex indices to store slots, queue them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpe_front
  import cpe_pkg::*;
#(
  parameter int MAX_VERTICES = CPE_MAX_VERTICES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tlast,
  input  wire logic [QLW-1:0]        fifo_level,
  output logic                       push,
  output cpe_qent_t                  push_data
);

  localparam int RECIP = (1 << RECIP_SH) / MAX_VERTICES;
  localparam int PRD_W = IDX_W + RECIP_SH;
  localparam int MOD_W = IDX_W + 17;
  localparam logic [PRD_W-1:0] RECIP_V = PRD_W'(RECIP);
  localparam logic [MOD_W-1:0] MOD_V   = MOD_W'(MAX_VERTICES);

  logic [IDX_W-1:0] in_vertex;
  logic [DUR_W-1:0] in_dur;
  logic [IDX_W-1:0] in_pred;
  logic             accept;
  logic [QLW:0]     occ;
  logic [PRD_W-1:0] prod_v;
  logic [PRD_W-1:0] prod_p;

  logic             s1_valid_r;
  logic [IDX_W-1:0] s1_vertex_r;
  logic [DUR_W-1:0] s1_dur_r;
  logic [IDX_W-1:0] s1_pred_r;
  logic             s1_last_r;
  logic [IDX_W-1:0] s1_qv_r;
  logic [IDX_W-1:0] s1_qp_r;

  // Remainder from an estimated quotient that is exact or one short.
  function automatic logic [IDX_W-1:0] slot_rem(input logic [IDX_W-1:0] x,
                                                input logic [IDX_W-1:0] q);
    logic [MOD_W-1:0] t;
    t = MOD_W'(x) - MOD_W'(q) * MOD_V;
    if (t >= MOD_V) begin
      t = t - MOD_V;
    end
    return t[IDX_W-1:0];
  endfunction

  assign in_vertex = in_tdata[IDX_W-1:0];
  assign in_dur    = in_tdata[IDX_W+DUR_W-1:IDX_W];
  assign in_pred   = in_tdata[2*IDX_W+DUR_W-1:IDX_W+DUR_W];

  // Hold back while the queue cannot take this request and the one in flight.
  assign occ       = (QLW+1)'(fifo_level) + (QLW+1)'(s1_valid_r);
  assign in_tready = occ < (QLW+1)'(QDEPTH);
  assign accept    = in_tvalid && in_tready;

  assign prod_v = PRD_W'(in_vertex) * RECIP_V;
  assign prod_p = PRD_W'(in_pred) * RECIP_V;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_vertex_r <= in_vertex;
      s1_dur_r    <= in_dur;
      s1_pred_r   <= in_pred;
      s1_last_r   <= in_tlast;
      s1_qv_r     <= prod_v[PRD_W-1:RECIP_SH];
      s1_qp_r     <= prod_p[PRD_W-1:RECIP_SH];
    end
  end

  assign push             = s1_valid_r;
  assign push_data.vertex = s1_vertex_r;
  assign push_data.dur    = s1_dur_r;
  assign push_data.pred   = s1_pred_r;
  assign push_data.vrem   = slot_rem(s1_vertex_r, s1_qv_r);
  assign push_data.prem   = slot_rem(s1_pred_r, s1_qp_r);
  assign push_data.last   = s1_last_r;

endmodule

`default_nettype wire

>>> rtl/core/cpe_back.sv
// ----------------------------------------------------------------------------
// cpe_back
// Read predecessor dates, track the critical list, store dates, emit results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpe_back
  import cpe_pkg::*;
#(
  parameter int MAX_VERTICES = CPE_MAX_VERTICES,
  parameter int MAX_PREDS    = CPE_MAX_PREDS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cpe_qent_t              head,
  input  wire logic [QLW-1:0]         fifo_level,
  output logic                        pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int PW = (MAX_PREDS > 1) ? $clog2(MAX_PREDS) : 1;
  localparam int CW = $clog2(MAX_PREDS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  state_t            state_r, state_nxt;
  cpe_qent_t         ent_r, ent_nxt;
  logic [DATE_W-1:0] best_r, best_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CW-1:0]     eidx_r, eidx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_vertex_r, out_vertex_nxt;
  logic [DATE_W-1:0] out_date_r, out_date_nxt;
  logic [IDX_W-1:0]  out_crit_r, out_crit_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic              out_last_r, out_last_nxt;

  logic              st_rd;
  logic [AW-1:0]     st_raddr;
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [DATE_W-1:0] st_wdate;
  logic [DUR_W-1:0]  st_wdur;
  logic [DATE_W-1:0] date_q;
  logic [DUR_W-1:0]  dur_q;

  logic              cb_we;
  logic [PW-1:0]     cb_waddr;
  logic              cb_re;
  logic [IDX_W-1:0]  crit_q;

  logic [DATE_W:0]   sum;
  logic [DATE_W-1:0] contrib;
  logic              run_end;
  logic [CW-1:0]     eidx_inc;

  cpe_ram #(.WIDTH(DATE_W), .DEPTH(MAX_VERTICES)) u_date_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdate),
    .rd_en   (st_rd),
    .rd_addr (st_raddr),
    .rd_data (date_q)
  );

  cpe_ram #(.WIDTH(DUR_W), .DEPTH(MAX_VERTICES)) u_duration_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdur),
    .rd_en   (st_rd),
    .rd_addr (st_raddr),
    .rd_data (dur_q)
  );

  cpe_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PREDS)) u_crit_buffer (
    .clk     (clk),
    .wr_en   (cb_we),
    .wr_addr (cb_waddr),
    .wr_data (ent_r.pred),
    .rd_en   (cb_re),
    .rd_addr (eidx_r[PW-1:0]),
    .rd_data (crit_q)
  );

  // Saturating finish date of the predecessor just read
  assign sum      = (DATE_W+1)'(date_q) + (DATE_W+1)'(dur_q);
  assign contrib  = sum[DATE_W] ? '1 : sum[DATE_W-1:0];
  assign eidx_inc = eidx_r + 1'b1;
  assign run_end  = (cnt_r == '0) || (eidx_inc == cnt_r);

  always_comb begin
    state_nxt      = state_r;
    ent_nxt        = ent_r;
    best_nxt       = best_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    eidx_nxt       = eidx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_vertex_nxt = out_vertex_r;
    out_date_nxt   = out_date_r;
    out_crit_nxt   = out_crit_r;
    out_ovf_nxt    = out_ovf_r;
    out_last_nxt   = out_last_r;
    pop            = 1'b0;
    st_rd          = 1'b0;
    st_raddr       = AW'(head.prem);
    st_we          = 1'b0;
    st_waddr       = AW'(ent_r.vrem);
    st_wdate       = best_r;
    st_wdur        = ent_r.dur;
    cb_we          = 1'b0;
    cb_waddr       = '0;
    cb_re          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (fifo_level != '0) begin
          pop     = 1'b1;
          ent_nxt = head;
          if (head.pred != '0) begin
            st_rd     = 1'b1;
            state_nxt = ST_READ;
          end else if (head.last) begin
            // No predecessor on the final entry: store the date as it stands
            st_we     = 1'b1;
            st_waddr  = AW'(head.vrem);
            st_wdur   = head.dur;
            eidx_nxt  = '0;
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      ST_READ: begin
        if (contrib > best_r) begin
          best_nxt = contrib;
          cb_we    = 1'b1;
          cb_waddr = '0;
          cnt_nxt  = CW'(1);
          ovf_nxt  = 1'b0;
        end else if (contrib == best_r) begin
          if (cnt_r < CW'(MAX_PREDS)) begin
            cb_we    = 1'b1;
            cb_waddr = cnt_r[PW-1:0];
            cnt_nxt  = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (ent_r.last) begin
          st_we     = 1'b1;
          st_wdate  = best_nxt;
          eidx_nxt  = '0;
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_EMIT_RD: begin
        cb_re     = 1'b1;
        state_nxt = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = ent_r.vertex;
          out_date_nxt   = best_r;
          out_crit_nxt   = (cnt_r == '0) ? '0 : crit_q;
          out_ovf_nxt    = ovf_r;
          out_last_nxt   = run_end;
          if (run_end) begin
            best_nxt  = '0;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            eidx_nxt  = eidx_inc;
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      best_r      <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      eidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      best_r      <= best_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      eidx_r      <= eidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ent_r        <= ent_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_date_r   <= out_date_nxt;
    out_crit_r   <= out_crit_nxt;
    out_ovf_r    <= out_ovf_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {
    (OUT_TDATA_W - 2*IDX_W - DATE_W - 1)'(0),
    out_ovf_r, out_crit_r, out_date_r, out_vertex_r
  };

endmodule

`default_nettype wire

>>> rtl/core/critical_path_earliest_dates.sv
// ----------------------------------------------------------------------------
// critical_path_earliest_dates
// Flow: an entry with a predecessor takes a store read, then a compare and
//   update; an entry without one is only popped. A final entry then gives each
//   result by a registered read of the critical-list buffer, then the output
//   register, which waits while the result side stalls.
// Reset: synchronous, active low; clears control state and the running best,
//   list count and overflow flag; the date and duration stores keep contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Earliest start dates on a task graph whose vertices arrive in topological
// order, each as a run of predecessor requests closed by tlast.
//
// Front end: register each request, reduce vertex and predecessor indices to
// store slots (reciprocal multiply, then one correcting subtract) and push the
// request into a short queue. While the queue has room the front keeps
// accepting, also while the back end is busy reading stores or emitting a
// run of results.
// Back end: pop a request, read the predecessor's date and duration, form the
// saturating finish date and update the running best and the critical list.
// On the final request, write the vertex's date and duration and emit one
// result per critical predecessor (one result with predecessor 0 when the
// list is empty) through an output register.

module critical_path_earliest_dates
  import cpe_pkg::*;
#(
  parameter int MAX_VERTICES = CPE_MAX_VERTICES,
  parameter int MAX_PREDS    = CPE_MAX_PREDS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Requests
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [9:0] vertex, [25:10] vertex_duration, [35:26] pred_vertex, [39:36] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tlast,   // last_of_vertex
  // Results
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [9:0] out_vertex, [41:10] earliest_date, [51:42] crit_pred,
  // [52] list_overflow, [55:53] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast   // last_result
);

  logic           q_push;
  cpe_qent_t      q_push_data;
  logic           q_pop;
  cpe_qent_t      q_head;
  logic [QLW-1:0] q_level;

  // Classify and index-reduce incoming requests
  cpe_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .fifo_level (q_level),
    .push       (q_push),
    .push_data  (q_push_data)
  );

  // Decouple the two halves so each can stall on its own
  cpe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .level     (q_level)
  );

  // Store access, critical list and result emission
  cpe_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_PREDS    (MAX_PREDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .fifo_level (q_level),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/core/cpe_checker.sv
// ----------------------------------------------------------------------------
// cpe_checker
// Port-level checks on the result stream of the earliest-date block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "critical_path_earliest_dates_assert.svh"

module cpe_checker
  import cpe_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast
);

  localparam int HDR_W = IDX_W + DATE_W;

  logic             acc;
  logic             open_r;
  logic [HDR_W-1:0] prev_r;

  assign acc = out_tvalid && out_tready;

  // Track an open run and the vertex/date it reports
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (acc) begin
      open_r <= !out_tlast;
    end
    if (acc) begin
      prev_r <= out_tdata[HDR_W-1:0];
    end
  end

  `CPE_ASSERT_NXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `CPE_ASSERT_IMP(a_run_same_hdr, clk, !rst_n, acc && open_r, out_tdata[HDR_W-1:0] == prev_r, "vertex or date changed inside a run")
  `CPE_ASSERT_IMP(a_empty_alone, clk, !rst_n, acc && (out_tdata[HDR_W+IDX_W-1:HDR_W] == '0), out_tlast && !open_r, "empty-list result not alone in its run")
  `CPE_ASSERT_NXT(a_reset_quiet, clk, 1'b0, !rst_n, !out_tvalid, "result valid right after reset")

endmodule

bind critical_path_earliest_dates cpe_checker u_cpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for critical_path_earliest_dates
// Streams predecessor requests for task-graph vertices in topological order
// and predicts each vertex's earliest date and critical predecessor list.
// Every reported result is compared field by field with the prediction,
// while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cpe_pkg::*;

  localparam int RANDOM_REQUESTS = 330;
  localparam int SETTLE_CYCLES   = 24;

  // One reported result of a vertex: its date and one critical predecessor
  typedef struct {
    bit [IDX_W-1:0]  vertex;
    bit [DATE_W-1:0] date;
    bit [IDX_W-1:0]  pred;
    bit              overflow;
    bit              last;
  } date_report_t;

  // Tracks stored dates and durations, the running best of the open vertex
  // and its critical list; queues the reports each closed vertex must give.
  class earliest_date_tracker;
    bit [DATE_W-1:0] date_of[CPE_MAX_VERTICES];
    bit [DUR_W-1:0]  dur_of[CPE_MAX_VERTICES];
    bit [DATE_W-1:0] best;
    bit [IDX_W-1:0]  crit_list[CPE_MAX_PREDS];
    int              crit_len;
    bit              dropped;
    date_report_t    due_reports[$];
    int              mismatches;

    function new();
      foreach (date_of[i]) begin
        date_of[i] = '0;
        dur_of[i]  = '0;
      end
      best       = '0;
      crit_len   = 0;
      dropped    = 1'b0;
      mismatches = 0;
    endfunction

    // Finish date of a stored vertex, clamped to the date range
    function bit [DATE_W-1:0] finish_date(bit [IDX_W-1:0] idx);
      bit [DATE_W:0] sum;
      sum = {1'b0, date_of[idx]} + {{(DATE_W-DUR_W+1){1'b0}}, dur_of[idx]};
      return sum[DATE_W] ? {DATE_W{1'b1}} : sum[DATE_W-1:0];
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    function void take_request(bit [IDX_W-1:0] v, bit [DUR_W-1:0] dur,
                               bit [IDX_W-1:0] p, bit last);
      bit [DATE_W-1:0] r;
      date_report_t    rep;
      if (p != '0) begin
        r = finish_date(p);
        if (r > best) begin
          // a strictly later finish restarts the list
          best         = r;
          crit_list[0] = p;
          crit_len     = 1;
          dropped      = 1'b0;
        end else if (r == best) begin
          if (crit_len < CPE_MAX_PREDS) begin
            crit_list[crit_len] = p;
            crit_len++;
          end else begin
            dropped = 1'b1;
          end
        end
      end
      if (!last) return;
      date_of[v] = best;
      dur_of[v]  = dur;
      rep.vertex   = v;
      rep.date     = best;
      rep.overflow = dropped;
      if (crit_len == 0) begin
        rep.pred = '0;
        rep.last = 1'b1;
        due_reports.push_back(rep);
      end
      for (int i = 0; i < crit_len; i++) begin
        rep.pred = crit_list[i];
        rep.last = (i == crit_len - 1);
        due_reports.push_back(rep);
      end
      best     = '0;
      crit_len = 0;
      dropped  = 1'b0;
    endfunction

    function void match_result(bit [IDX_W-1:0] v, bit [DATE_W-1:0] date,
                               bit [IDX_W-1:0] p, bit ovf, bit last);
      date_report_t want;
      if (due_reports.size() == 0) begin
        $error("unexpected result: vertex %0d date %0d pred %0d", v, date, p);
        mismatches++;
        return;
      end
      want = due_reports.pop_front();
      if (v != want.vertex) begin
        $error("out_vertex: expected %0d, got %0d", want.vertex, v);
        mismatches++;
      end
      if (date != want.date) begin
        $error("earliest_date: expected %0d, got %0d", want.date, date);
        mismatches++;
      end
      if (p != want.pred) begin
        $error("crit_pred: expected %0d, got %0d", want.pred, p);
        mismatches++;
      end
      if (ovf != want.overflow) begin
        $error("list_overflow: expected %0d, got %0d", want.overflow, ovf);
        mismatches++;
      end
      if (last != want.last) begin
        $error("last_result: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tlast  = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  earliest_date_tracker tracker;

  // Vertices whose date is stored and may serve as predecessors
  bit             known[CPE_MAX_VERTICES];
  int             known_ids[$];
  // Stored vertices that share one finish date, for building ties
  int             tie_peers[$];
  // When set, requests go out back to back
  bit             burst = 1'b0;

  always #1 clk = ~clk;

  critical_path_earliest_dates uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Drive one predecessor request, hold it until accepted, then record it.
  // tvalid stays high after acceptance; the next call lowers it if it idles.
  task automatic send_entry(bit [IDX_W-1:0] v, bit [DUR_W-1:0] dur,
                            bit [IDX_W-1:0] p, bit last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-2*IDX_W-DUR_W){1'b0}}, p, dur, v};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    tracker.take_request(v, dur, p, last);
    // vertex 0 is stored but can never be named as a predecessor
    if (last && v != '0 && !known[v]) begin
      known[v] = 1'b1;
      known_ids.push_back(v);
    end
  endtask

  // Drop tvalid and hold off until every predicted result has arrived
  task automatic wait_all_reported();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Collect the stored vertices whose finish date equals that of a random one
  function automatic void fill_tie_peers();
    int w;
    bit [DATE_W-1:0] target;
    tie_peers.delete();
    w      = known_ids[$urandom_range(0, known_ids.size() - 1)];
    target = tracker.finish_date(w);
    foreach (known_ids[i])
      if (tracker.finish_date(known_ids[i]) == target) tie_peers.push_back(known_ids[i]);
  endfunction

  // Result side: stall a random number of cycles before each result, with
  // stretches where it stays ready throughout.
  initial begin
    int stall  = 0;
    int streak = 0;
    bit eager  = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (streak == 0) begin
        streak = $urandom_range(20, 60);
        eager  = ($urandom_range(0, 3) == 0);
      end
      streak--;
      stall = eager ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Check every accepted result; values sampled here predate this edge's updates
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.match_result(out_tdata[IDX_W-1:0],
                           out_tdata[IDX_W+DATE_W-1:IDX_W],
                           out_tdata[2*IDX_W+DATE_W-1:IDX_W+DATE_W],
                           out_tdata[2*IDX_W+DATE_W],
                           out_tlast);
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int sent = 0;
    int pick;
    int len;
    int odd_slot;
    bit [IDX_W-1:0] v;
    bit [IDX_W-1:0] p;
    bit [DUR_W-1:0] dur;

    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no predecessor, so an empty list and date 0
    send_entry(10'd1, 16'h0000, 10'd0, 1'b1);
    // A zero finish date ties the initial best and is listed
    send_entry(10'd2, 16'hFFFF, 10'd1, 1'b1);
    send_entry(10'd1023, 16'h5A5A, 10'd2, 1'b1);
    // Vertex 0 is stored; predecessor with every index bit set
    send_entry(10'd0, 16'h00FF, 10'd1023, 1'b1);
    // Seventeen ties on one predecessor fill the list and drop the last;
    // the vertex field wanders inside the run, only the final one counts
    for (int i = 0; i < 17; i++)
      send_entry((i == 8) ? 10'd5 : 10'd768, 16'h1234, 10'd2, 1'b0);
    send_entry(10'd768, 16'h8000, 10'd1, 1'b1);
    // A later finish clears the list; a no-predecessor request adds nothing
    send_entry(10'd300, 16'h0000, 10'd0, 1'b0);
    send_entry(10'd301, 16'h0000, 10'd2, 1'b0);
    send_entry(10'd300, 16'h0001, 10'd1023, 1'b1);

    wait_all_reported();

    // Random: well-formed vertex runs built from stored vertices, many of
    // them with equal finish dates so ties and full lists recur
    while (sent < RANDOM_REQUESTS) begin
      burst = ($urandom_range(0, 9) < 3);
      pick  = $urandom_range(0, 99);
      v     = ($urandom_range(0, 19) == 0) ? 10'd0 : 10'($urandom_range(1, 1023));
      case ($urandom_range(0, 9))
        0, 1:    dur = 16'd0;
        2:       dur = 16'd1;
        3:       dur = 16'd7;
        4:       dur = 16'hFFFF;
        default: dur = 16'($urandom);
      endcase
      fill_tie_peers();
      if (pick < 10) begin
        // noise: no-predecessor requests with wandering vertex fields
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
          send_entry((i == len - 1) ? v : 10'($urandom), dur, 10'd0, i == len - 1);
      end else if (pick < 25) begin
        // wide fan-in of tied predecessors, now and then beaten by another
        len      = $urandom_range(17, 20);
        odd_slot = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
          p = (i == odd_slot) ? 10'(known_ids[$urandom_range(0, known_ids.size() - 1)])
                              : 10'(tie_peers[$urandom_range(0, tie_peers.size() - 1)]);
          send_entry(v, dur, p, i == len - 1);
        end
      end else begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 9))
            0:       p = 10'd0;
            1, 2:    p = 10'(known_ids[$urandom_range(0, known_ids.size() - 1)]);
            default: p = 10'(tie_peers[$urandom_range(0, tie_peers.size() - 1)]);
          endcase
          send_entry((i < len - 1 && $urandom_range(0, 9) == 0) ? 10'($urandom) : v,
                     dur, p, i == len - 1);
        end
      end
      sent += len;
      if ($urandom_range(0, 29) == 0) wait_all_reported();
    end

    // Drain, then allow for anything stray still in the pipeline
    wait_all_reported();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> critical_path_earliest_dates.f
+incdir+rtl/core
rtl/core/cpe_pkg.sv
rtl/core/cpe_ram.sv
rtl/core/cpe_fifo.sv
rtl/core/cpe_front.sv
rtl/core/cpe_back.sv
rtl/core/critical_path_earliest_dates.sv
rtl/core/cpe_checker.sv
tb/testbench.sv
